[src/tbo_pkg.sv]
`timescale 1ns / 1ps
package tbo_pkg;
  localparam int unsigned CoordWidth = 32;
  localparam int unsigned HalfWidth  = CoordWidth - 1;
  localparam int unsigned RelWidth   = CoordWidth + 1;
  localparam int unsigned EdgeWidth  = CoordWidth + 2;
  localparam int unsigned ProdWidth  = 2 * EdgeWidth;
  localparam int unsigned ProjWidth  = ProdWidth + 1;
  localparam int unsigned NormWidth  = ProjWidth;
  localparam int unsigned DotWidth   = NormWidth + EdgeWidth + 3;
  // plane normal is split in two halves so each plane product stays narrow
  localparam int unsigned NormLoWidth = NormWidth / 2 + 1;
  localparam int unsigned PartHiWidth = NormWidth - NormLoWidth + EdgeWidth;
  localparam int unsigned PartLoWidth = NormLoWidth + 1 + EdgeWidth;
  localparam int unsigned AddrWidth  = 4;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoPtrW   = 2;

  localparam logic [AddrWidth-1:0] AddrHalfX = 4'h0;
  localparam logic [AddrWidth-1:0] AddrHalfY = 4'h4;
  localparam logic [AddrWidth-1:0] AddrHalfZ = 4'h8;

  typedef logic signed [RelWidth-1:0]    rel_t;
  typedef logic signed [EdgeWidth-1:0]   edge_t;
  typedef logic signed [ProdWidth-1:0]   prod_t;
  typedef logic signed [ProjWidth-1:0]   proj_t;
  typedef logic signed [DotWidth-1:0]    dot_t;
  typedef logic signed [PartHiWidth-1:0] part_hi_t;
  typedef logic signed [PartLoWidth-1:0] part_lo_t;

  // relative vertices and edges handed from the front part to the back part
  typedef struct packed {
    rel_t  [2:0][2:0] v;
    edge_t [2:0][2:0] e;
  } geom_t;
endpackage

[src/triangle_box_overlap_test_unit.sv]
`timescale 1ns / 1ps
// separating-axis triangle versus axis-aligned box test: push one word holding the box
// center and three vertices (signed Q16.16), pop one overlap bit per word in order; a
// word can be taken every cycle while full is low, and its bit passes the front register,
// the decoupling queue and five back stages before it shows on the pop side; with pop
// held low, full rises once ten words are held inside; half sizes come from three APB
// registers at byte offsets 0, 4 and 8 and must only be written while no word is in
// flight
module triangle_box_overlap_test_unit import tbo_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [AddrWidth-1:0]         paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         push,
  output logic                         full,
  input  logic signed [CoordWidth-1:0] center_x_i,
  input  logic signed [CoordWidth-1:0] center_y_i,
  input  logic signed [CoordWidth-1:0] center_z_i,
  input  logic signed [CoordWidth-1:0] vertex0_x_i,
  input  logic signed [CoordWidth-1:0] vertex0_y_i,
  input  logic signed [CoordWidth-1:0] vertex0_z_i,
  input  logic signed [CoordWidth-1:0] vertex1_x_i,
  input  logic signed [CoordWidth-1:0] vertex1_y_i,
  input  logic signed [CoordWidth-1:0] vertex1_z_i,
  input  logic signed [CoordWidth-1:0] vertex2_x_i,
  input  logic signed [CoordWidth-1:0] vertex2_y_i,
  input  logic signed [CoordWidth-1:0] vertex2_z_i,
  output logic                         empty,
  input  logic                         pop,
  output logic                         overlap_o
);
  logic [HalfWidth-1:0] half_q [3];
  logic                 wr_en;

  // configuration registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q[0] <= '0;
      half_q[1] <= '0;
      half_q[2] <= '0;
    end else if (wr_en) begin
      if (paddr == AddrHalfX) half_q[0] <= pwdata[HalfWidth-1:0];
      if (paddr == AddrHalfY) half_q[1] <= pwdata[HalfWidth-1:0];
      if (paddr == AddrHalfZ) half_q[2] <= pwdata[HalfWidth-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == AddrHalfX) prdata = {1'b0, half_q[0]};
    if (paddr == AddrHalfY) prdata = {1'b0, half_q[1]};
    if (paddr == AddrHalfZ) prdata = {1'b0, half_q[2]};
  end

  // front: relative vertices and edges
  logic signed [CoordWidth-1:0] c_in [3];
  logic signed [CoordWidth-1:0] p_in [3][3];
  logic  fr_ready, fr_valid, q_full, q_empty, bk_ready, bk_valid;
  geom_t fr_geom, q_geom;

  assign c_in[0] = center_x_i;
  assign c_in[1] = center_y_i;
  assign c_in[2] = center_z_i;
  assign p_in[0][0] = vertex0_x_i;
  assign p_in[0][1] = vertex0_y_i;
  assign p_in[0][2] = vertex0_z_i;
  assign p_in[1][0] = vertex1_x_i;
  assign p_in[1][1] = vertex1_y_i;
  assign p_in[1][2] = vertex1_z_i;
  assign p_in[2][0] = vertex2_x_i;
  assign p_in[2][1] = vertex2_y_i;
  assign p_in[2][2] = vertex2_z_i;
  assign full = !fr_ready;

  tbo_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (push),
    .ready_i (!q_full),
    .ready_o (fr_ready),
    .c_i     (c_in),
    .p_i     (p_in),
    .valid_o (fr_valid),
    .geom_o  (fr_geom)
  );

  // decoupling queue between front and back
  tbo_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .full_o  (q_full),
    .data_i  (fr_geom),
    .pop_i   (bk_ready),
    .empty_o (q_empty),
    .data_o  (q_geom)
  );

  // back: each edge crossed with each box axis, the box faces, the triangle plane
  tbo_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (!q_empty),
    .ready_o   (bk_ready),
    .geom_i    (q_geom),
    .half_i    (half_q),
    .valid_o   (bk_valid),
    .ready_i   (pop),
    .overlap_o (overlap_o)
  );

  assign empty = !bk_valid;
endmodule

[src/tbo_front.sv]
`timescale 1ns / 1ps
module tbo_front import tbo_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic                         ready_i,
  output logic                         ready_o,
  input  logic signed [CoordWidth-1:0] c_i [3],
  input  logic signed [CoordWidth-1:0] p_i [3][3],
  output logic                         valid_o,
  output geom_t                        geom_o
);
  logic  valid_q;
  geom_t geom_q, geom_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign geom_o  = geom_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int d = 0; d < 3; d++) begin
        geom_d.v[k][d] = RelWidth'(p_i[k][d]) - RelWidth'(c_i[d]);
      end
    end
    for (int k = 0; k < 3; k++) begin
      for (int d = 0; d < 3; d++) begin
        geom_d.e[k][d] = EdgeWidth'(p_i[(k+1)%3][d]) - EdgeWidth'(p_i[k][d]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      geom_q <= geom_d;
    end
  end
endmodule

[src/tbo_fifo.sv]
`timescale 1ns / 1ps
module tbo_fifo import tbo_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  output logic  full_o,
  input  geom_t data_i,
  input  logic  pop_i,
  output logic  empty_o,
  output geom_t data_o
);
  geom_t             mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, rd_q;
  logic [FifoPtrW:0]   cnt_q;

  assign full_o  = cnt_q == (FifoPtrW+1)'(FifoDepth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wr_q <= wr_q + 1'b1;
      if (pop_i && !empty_o) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (FifoPtrW+1)'(push_i && !full_o) - (FifoPtrW+1)'(pop_i && !empty_o);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wr_q] <= data_i;
  end
endmodule

[src/tbo_back.sv]
`timescale 1ns / 1ps
module tbo_back import tbo_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  geom_t                geom_i,
  input  logic [HalfWidth-1:0] half_i [3],
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic                 overlap_o
);
  // stage 1: products and face tests; stage 2: axis compare and plane normal; stage 3: split plane products
  // stage 4: plane terms; output stage: plane sums
  logic s1_q, s2_q, s3_q, s4_q, out_vld_q;
  logic adv1, adv2, adv3, adv4, adv_out;
  logic out_q;

  assign adv_out = !out_vld_q || ready_i;
  assign adv4    = !s4_q || adv_out;
  assign adv3    = !s3_q || adv4;
  assign adv2    = !s2_q || adv3;
  assign adv1    = !s1_q || adv2;
  assign ready_o = adv1;
  assign valid_o = out_vld_q;
  assign overlap_o = out_q;

  edge_t a_s [9], b_s [9], abs_a [9], abs_b [9];
  rel_t  pa [9], pb [9], qa [9], qb [9];
  edge_t hh0 [9], hh1 [9];
  edge_t hs_d [3];

  // axis test descriptors: proj = a*p[i0] - b*p[i1], radius = |a|*h[i0] + |b|*h[i1]
  always_comb begin
    for (int d = 0; d < 3; d++) begin
      hs_d[d] = EdgeWidth'($signed({1'b0, half_i[d]}));
    end
    for (int t = 0; t < 9; t++) begin
      int unsigned k;
      int unsigned ax;
      int unsigned i0, i1, pv, qv;
      k  = t / 3;
      ax = t % 3;
      unique case (ax)
        0: begin a_s[t] = geom_i.e[k][2]; b_s[t] = geom_i.e[k][1]; i0 = 1; i1 = 2; end
        1: begin a_s[t] = geom_i.e[k][0]; b_s[t] = geom_i.e[k][2]; i0 = 2; i1 = 0; end
        default: begin a_s[t] = geom_i.e[k][1]; b_s[t] = geom_i.e[k][0]; i0 = 0; i1 = 1; end
      endcase
      if (k == 0) begin pv = (ax == 2) ? 1 : 0; qv = 2; end
      else if (k == 1) begin pv = 0; qv = (ax == 2) ? 1 : 2; end
      else begin pv = (ax == 2) ? 1 : 0; qv = (ax == 2) ? 2 : 1; end
      pa[t] = geom_i.v[pv][i0];
      pb[t] = geom_i.v[pv][i1];
      qa[t] = geom_i.v[qv][i0];
      qb[t] = geom_i.v[qv][i1];
      hh0[t] = hs_d[i0];
      hh1[t] = hs_d[i1];
      abs_a[t] = (a_s[t] < 0) ? -a_s[t] : a_s[t];
      abs_b[t] = (b_s[t] < 0) ? -b_s[t] : b_s[t];
    end
  end

  prod_t p_ua_q [9], p_ub_q [9], p_va_q [9], p_vb_q [9], r_a_q [9], r_b_q [9];
  prod_t n_p_q [6];
  edge_t lo_q [3], hi_q [3];
  logic  face_sep_q;
  edge_t e0 [3], e1 [3];
  edge_t lo_d [3], hi_d [3];
  logic  face_sep_d;

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      e0[d] = geom_i.e[0][d];
      e1[d] = geom_i.e[1][d];
      // box corner offsets seen from v0 along each axis
      lo_d[d] = -hs_d[d] - EdgeWidth'(geom_i.v[0][d]);
      hi_d[d] = hs_d[d] - EdgeWidth'(geom_i.v[0][d]);
    end
    face_sep_d = 1'b0;
    for (int d = 0; d < 3; d++) begin
      rel_t mn, mx;
      mn = geom_i.v[0][d];
      mx = geom_i.v[0][d];
      for (int k = 1; k < 3; k++) begin
        if (geom_i.v[k][d] < mn) mn = geom_i.v[k][d];
        if (geom_i.v[k][d] > mx) mx = geom_i.v[k][d];
      end
      if (EdgeWidth'(mn) > hs_d[d] || EdgeWidth'(mx) < -hs_d[d]) face_sep_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && valid_i) begin
      for (int t = 0; t < 9; t++) begin
        p_ua_q[t] <= ProdWidth'(a_s[t]) * ProdWidth'(pa[t]);
        p_ub_q[t] <= ProdWidth'(b_s[t]) * ProdWidth'(pb[t]);
        p_va_q[t] <= ProdWidth'(a_s[t]) * ProdWidth'(qa[t]);
        p_vb_q[t] <= ProdWidth'(b_s[t]) * ProdWidth'(qb[t]);
        r_a_q[t]  <= ProdWidth'(abs_a[t]) * ProdWidth'(hh0[t]);
        r_b_q[t]  <= ProdWidth'(abs_b[t]) * ProdWidth'(hh1[t]);
      end
      n_p_q[0] <= ProdWidth'(e0[1]) * ProdWidth'(e1[2]);
      n_p_q[1] <= ProdWidth'(e0[2]) * ProdWidth'(e1[1]);
      n_p_q[2] <= ProdWidth'(e0[2]) * ProdWidth'(e1[0]);
      n_p_q[3] <= ProdWidth'(e0[0]) * ProdWidth'(e1[2]);
      n_p_q[4] <= ProdWidth'(e0[0]) * ProdWidth'(e1[1]);
      n_p_q[5] <= ProdWidth'(e0[1]) * ProdWidth'(e1[0]);
      lo_q       <= lo_d;
      hi_q       <= hi_d;
      face_sep_q <= face_sep_d;
    end
  end

  // stage 2
  logic  axis_sep_d, sep2_q;
  proj_t n_d [3], n_q [3];
  edge_t lo_2q [3], hi_2q [3];

  always_comb begin
    axis_sep_d = 1'b0;
    for (int t = 0; t < 9; t++) begin
      proj_t p, q, r, mn, mx;
      p = ProjWidth'(p_ua_q[t]) - ProjWidth'(p_ub_q[t]);
      q = ProjWidth'(p_va_q[t]) - ProjWidth'(p_vb_q[t]);
      r = ProjWidth'(r_a_q[t]) + ProjWidth'(r_b_q[t]);
      mn = (p < q) ? p : q;
      mx = (p < q) ? q : p;
      if (mn > r || mx < -r) axis_sep_d = 1'b1;
    end
    n_d[0] = ProjWidth'(n_p_q[0]) - ProjWidth'(n_p_q[1]);
    n_d[1] = ProjWidth'(n_p_q[2]) - ProjWidth'(n_p_q[3]);
    n_d[2] = ProjWidth'(n_p_q[4]) - ProjWidth'(n_p_q[5]);
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && s1_q) begin
      sep2_q <= axis_sep_d || face_sep_q;
      n_q    <= n_d;
      lo_2q  <= lo_q;
      hi_2q  <= hi_q;
    end
  end

  // stage 3: plane products, normal split into a signed upper and an unsigned lower half
  edge_t    smin_d [3], smax_d [3];
  part_hi_t mh_min_q [3], mh_max_q [3];
  part_lo_t ml_min_q [3], ml_max_q [3];
  logic     sep3_q;

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      smin_d[d] = (n_q[d] > 0) ? lo_2q[d] : hi_2q[d];
      smax_d[d] = (n_q[d] > 0) ? hi_2q[d] : lo_2q[d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3 && s2_q) begin
      sep3_q <= sep2_q;
      for (int d = 0; d < 3; d++) begin
        mh_min_q[d] <= PartHiWidth'($signed(n_q[d][NormWidth-1:NormLoWidth]))
                       * PartHiWidth'(smin_d[d]);
        mh_max_q[d] <= PartHiWidth'($signed(n_q[d][NormWidth-1:NormLoWidth]))
                       * PartHiWidth'(smax_d[d]);
        ml_min_q[d] <= PartLoWidth'($signed({1'b0, n_q[d][NormLoWidth-1:0]}))
                       * PartLoWidth'(smin_d[d]);
        ml_max_q[d] <= PartLoWidth'($signed({1'b0, n_q[d][NormLoWidth-1:0]}))
                       * PartLoWidth'(smax_d[d]);
      end
    end
  end

  // stage 4: recombine the halves per axis
  dot_t pmin_q [3], pmax_q [3];
  logic sep4_q;

  always_ff @(posedge clk_i) begin
    if (adv4 && s3_q) begin
      sep4_q <= sep3_q;
      for (int d = 0; d < 3; d++) begin
        pmin_q[d] <= (DotWidth'(mh_min_q[d]) <<< NormLoWidth) + DotWidth'(ml_min_q[d]);
        pmax_q[d] <= (DotWidth'(mh_max_q[d]) <<< NormLoWidth) + DotWidth'(ml_max_q[d]);
      end
    end
  end

  dot_t dmin, dmax;
  assign dmin = pmin_q[0] + pmin_q[1] + pmin_q[2];
  assign dmax = pmax_q[0] + pmax_q[1] + pmax_q[2];

  always_ff @(posedge clk_i) begin
    if (adv_out && s4_q) begin
      out_q <= !sep4_q && !(dmin > 0) && !(dmax < 0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q      <= 1'b0;
      s2_q      <= 1'b0;
      s3_q      <= 1'b0;
      s4_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv1)    s1_q      <= valid_i;
      if (adv2)    s2_q      <= s1_q;
      if (adv3)    s3_q      <= s2_q;
      if (adv4)    s4_q      <= s3_q;
      if (adv_out) out_vld_q <= s4_q;
    end
  end
endmodule

[verif/tb_triangle_box_overlap_test_unit.sv]
`timescale 1ns / 1ps
// overlap test bench: words go in through the push side, overlap bits come out of the pop side
// and are checked in order against a widened-integer separating-axis predictor

class overlap_scoreboard;
  bit expected_bits[$];
  int unsigned mismatches;

  function void note_word(bit ov);
    expected_bits.push_back(ov);
  endfunction

  function void check_bit(bit actual);
    bit want;
    if (expected_bits.size() == 0) begin
      $display("%0t: unexpected overlap word, expected none, actual %0b", $time, actual);
      mismatches++;
    end else begin
      want = expected_bits.pop_front();
      if (want !== actual) begin
        $display("%0t: overlap mismatch, expected %0b, actual %0b", $time, want, actual);
        mismatches++;
      end
    end
  endfunction
endclass

module tb_triangle_box_overlap_test_unit;
  import tbo_pkg::*;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef coord_t word_t [12];

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned RandomWords   = 1550;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic push = 1'b0;
  logic full;
  coord_t word_in [12];
  logic empty;
  logic pop = 1'b0;
  logic overlap_o;

  overlap_scoreboard board = new();
  // half extents as the predictor sees them
  wide_t half_ext [3];
  bit allow_idle = 1'b1;
  bit long_hold = 1'b0;
  int unsigned quiet_cycles = 0;

  initial for (int i = 0; i < 12; i++) word_in[i] = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  triangle_box_overlap_test_unit dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .push, .full,
    .center_x_i(word_in[0]), .center_y_i(word_in[1]), .center_z_i(word_in[2]),
    .vertex0_x_i(word_in[3]), .vertex0_y_i(word_in[4]), .vertex0_z_i(word_in[5]),
    .vertex1_x_i(word_in[6]), .vertex1_y_i(word_in[7]), .vertex1_z_i(word_in[8]),
    .vertex2_x_i(word_in[9]), .vertex2_y_i(word_in[10]), .vertex2_z_i(word_in[11]),
    .empty, .pop, .overlap_o
  );

  function automatic wide_t abs_w(wide_t a);
    return (a < 0) ? -a : a;
  endfunction

  // separated when the projected interval [min,max] misses [-rad,rad]
  function automatic bit misses(wide_t p, wide_t q, wide_t rad);
    wide_t lo, hi;
    lo = (p < q) ? p : q;
    hi = (p < q) ? q : p;
    return (lo > rad) || (hi < -rad);
  endfunction

  // edge cross x axis: a,b are edge z and y components
  function automatic bit cut_x(wide_t a, wide_t b, wide_t p[3], wide_t q[3]);
    return misses(a*p[1] - b*p[2], a*q[1] - b*q[2],
                  abs_w(a)*half_ext[1] + abs_w(b)*half_ext[2]);
  endfunction

  function automatic bit cut_y(wide_t a, wide_t b, wide_t p[3], wide_t q[3]);
    return misses(b*p[2] - a*p[0], b*q[2] - a*q[0],
                  abs_w(a)*half_ext[0] + abs_w(b)*half_ext[2]);
  endfunction

  function automatic bit cut_z(wide_t a, wide_t b, wide_t p[3], wide_t q[3]);
    return misses(a*p[0] - b*p[1], a*q[0] - b*q[1],
                  abs_w(a)*half_ext[0] + abs_w(b)*half_ext[1]);
  endfunction

  function automatic bit predict_overlap(word_t w);
    wide_t v0[3], v1[3], v2[3], e0[3], e1[3], e2[3], nrm[3];
    wide_t lo, hi, dmin, dmax, mn, mx;
    for (int d = 0; d < 3; d++) begin
      v0[d] = wide_t'(w[3+d]) - wide_t'(w[d]);
      v1[d] = wide_t'(w[6+d]) - wide_t'(w[d]);
      v2[d] = wide_t'(w[9+d]) - wide_t'(w[d]);
    end
    for (int d = 0; d < 3; d++) begin
      e0[d] = v1[d] - v0[d];
      e1[d] = v2[d] - v1[d];
      e2[d] = v0[d] - v2[d];
    end
    // cross products of every edge with the x, y and z axes
    if (cut_x(e0[2], e0[1], v0, v2)) return 1'b0;
    if (cut_y(e0[2], e0[0], v0, v2)) return 1'b0;
    if (cut_z(e0[1], e0[0], v1, v2)) return 1'b0;
    if (cut_x(e1[2], e1[1], v0, v2)) return 1'b0;
    if (cut_y(e1[2], e1[0], v0, v2)) return 1'b0;
    if (cut_z(e1[1], e1[0], v0, v1)) return 1'b0;
    if (cut_x(e2[2], e2[1], v0, v1)) return 1'b0;
    if (cut_y(e2[2], e2[0], v0, v1)) return 1'b0;
    if (cut_z(e2[1], e2[0], v1, v2)) return 1'b0;
    // box faces
    for (int d = 0; d < 3; d++) begin
      mn = v0[d]; mx = v0[d];
      if (v1[d] < mn) mn = v1[d];
      if (v1[d] > mx) mx = v1[d];
      if (v2[d] < mn) mn = v2[d];
      if (v2[d] > mx) mx = v2[d];
      if (mn > half_ext[d] || mx < -half_ext[d]) return 1'b0;
    end
    // triangle plane, normal e0 x e1
    nrm[0] = e0[1]*e1[2] - e0[2]*e1[1];
    nrm[1] = e0[2]*e1[0] - e0[0]*e1[2];
    nrm[2] = e0[0]*e1[1] - e0[1]*e1[0];
    dmin = 0; dmax = 0;
    for (int d = 0; d < 3; d++) begin
      lo = -half_ext[d] - v0[d];
      hi = half_ext[d] - v0[d];
      dmin += nrm[d] * ((nrm[d] > 0) ? lo : hi);
      dmax += nrm[d] * ((nrm[d] > 0) ? hi : lo);
    end
    if (dmin > 0) return 1'b0;
    return dmax >= 0;
  endfunction

  // called at a falling edge, returns at a falling edge after the access with psel low again
  task automatic write_half(logic [AddrWidth-1:0] addr, int idx, logic [31:0] data);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk_i) penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    half_ext[idx] = wide_t'(data[HalfWidth-1:0]);
    @(negedge clk_i) psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_box(logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
    write_half(AddrHalfX, 0, hx);
    write_half(AddrHalfY, 1, hy);
    write_half(AddrHalfZ, 2, hz);
  endtask

  // stop pushing, then wait for the result queue to drain plus pipeline latency
  task automatic drain;
    push <= 1'b0;
    while (board.expected_bits.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  // push one word, called at a falling edge, returns at a falling edge
  task automatic send_word(word_t w);
    int gap;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    for (int i = 0; i < 12; i++) word_in[i] <= w[i];
    push <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    board.note_word(predict_overlap(w));
    @(negedge clk_i);
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom());
      1: return coord_t'($urandom_range(0, 32'h0004_0000)) - coord_t'(32'h0002_0000);
      default: return coord_t'($urandom_range(0, 32'h0200_0000)) - coord_t'(32'h0100_0000);
    endcase
  endfunction

  // random triangle, mostly near a random box center
  function automatic word_t rand_word();
    word_t w;
    int mode;
    mode = $urandom_range(0, 9);
    for (int d = 0; d < 3; d++) w[d] = (mode == 0) ? coord_t'($urandom()) : rand_coord(2);
    for (int i = 3; i < 12; i++)
      w[i] = (mode == 0) ? coord_t'($urandom())
                         : w[(i%3)] + rand_coord((mode < 5) ? 1 : 2);
    if (mode == 9) begin
      // each coordinate of v2 copied from v0 or v1, so vertices may repeat
      for (int d = 0; d < 3; d++) w[9+d] = ($urandom_range(0, 1)) ? w[3+d] : w[6+d];
    end
    return w;
  endfunction

  function automatic word_t fill_word(coord_t c, coord_t a, coord_t b, coord_t d);
    word_t w;
    for (int i = 0; i < 3; i++) begin
      w[i] = c; w[3+i] = a; w[6+i] = b; w[9+i] = d;
    end
    return w;
  endfunction

  // receiver: random pop stalls, and one long hold while the sender keeps pushing
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        pop <= 1'b0;
        repeat (60) @(negedge clk_i);
        long_hold = 1'b0;
      end
      if (allow_idle && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 5);
        pop <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // sample and check at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) board.check_bit(overlap_o);
    if (rst_ni && ((pop && !empty) || (push && !full))) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    word_t w;
    half_ext[0] = 0; half_ext[1] = 0; half_ext[2] = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    @(negedge clk_i);

    // point box at reset values, then extremes
    send_word(fill_word(0, 0, 0, 0));
    send_word(fill_word(0, 32'sh0001_0000, 0, 0));
    drain();
    set_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(fill_word(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF));
    send_word(fill_word(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    for (int i = 0; i < 12; i++) w[i] = (i % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    send_word(w);
    for (int i = 0; i < 12; i++) w[i] = (i % 3 == 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    send_word(w);
    for (int i = 0; i < 12; i++) w[i] = coord_t'(32'hFFFF_FFFF);
    send_word(w);
    drain();
    set_box(32'h0001_0000, 32'h0000_8000, 32'hFFFF_FFFF);
    // two triangles crossing the box, then two outside it: one on the x face plane, one just beyond
    w = fill_word(0, 0, 0, 0);
    w[3] = 32'shFFFE_0000; w[6] = 32'sh0002_0000; w[10] = 32'sh0002_0000;
    send_word(w);
    w[11] = 32'sh0003_0000;
    send_word(w);
    w = fill_word(0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
    w[7] = 32'sh0002_0000; w[11] = 32'sh0002_0000;
    send_word(w);
    w = fill_word(0, 32'sh0001_0001, 32'sh0001_0001, 32'sh0001_0001);
    w[7] = 32'sh0002_0000; w[11] = 32'sh0002_0000;
    send_word(w);
    for (int i = 0; i < 8; i++) send_word(rand_word());
    drain();

    // random phases over several box sizes; long receiver hold in the first
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_box(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        1: set_box(0, 32'h0000_4000, 32'h0008_0000);
        2: set_box($urandom_range(0, 32'h0040_0000), $urandom_range(0, 32'h0040_0000),
                   $urandom_range(0, 32'h0040_0000));
        3: set_box(32'h7FFF_FFFF, 0, $urandom());
        4: set_box($urandom_range(0, 32'h0100_0000), $urandom_range(0, 32'h0100_0000),
                   $urandom_range(0, 32'h0100_0000));
        default: begin
          set_box(32'h0002_0000, 32'h0001_8000, 32'h0003_0000);
          allow_idle = 1'b0;
        end
      endcase
      if (phase == 0) long_hold = 1'b1;
      for (int n = 0; n < RandomWords / 6; n++) send_word(rand_word());
      drain();
    end

    if (board.mismatches == 0 && board.expected_bits.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

[files.f]
src/tbo_pkg.sv
src/tbo_front.sv
src/tbo_fifo.sv
src/tbo_back.sv
src/triangle_box_overlap_test_unit.sv
verif/tb_triangle_box_overlap_test_unit.sv
